[src/life_generation_engine_macros.svh]
// assertion macros for the life generation engine checker
// expects signals named clk and rst in the scope where a macro is used
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define LGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/lge_pkg.sv]
// shared types and constants for the life generation engine
// no dependencies
package lge_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W     = 7;
  localparam int POP_W     = 13;
  localparam int FIELD_W   = 6;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;
  localparam int NB_W      = 4;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_LOAD = 2'd0;
  localparam func_t FUNC_STEP = 2'd1;
  localparam func_t FUNC_READ = 2'd2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROWS = 1'd0;
  localparam cfg_idx_t CFG_COLS = 1'd1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam logic [POP_W-1:0] POP_MAX   = '1;

  localparam logic [NB_W-1:0] SURVIVE_LOW  = 4'd2;
  localparam logic [NB_W-1:0] SURVIVE_HIGH = 4'd3;
  localparam logic [NB_W-1:0] BIRTH_COUNT  = 4'd3;

  // status of one cell from the rule unit
  typedef struct packed {
    logic alive;
    logic next_alive;
  } rule_out_t;

endpackage

[src/lge_cell_rule.sv]
// shared B3/S23 rule unit: neighbor count and next state of one cell
// depends on lge_pkg
module lge_cell_rule (
  input  logic [2:0]         up_bits,
  input  logic [2:0]         mid_bits,
  input  logic [2:0]         dn_bits,
  output lge_pkg::rule_out_t res
);
  import lge_pkg::*;

  logic [NB_W-1:0] count;

  always_comb begin
    count = NB_W'(up_bits[0]) + NB_W'(up_bits[1]) + NB_W'(up_bits[2])
          + NB_W'(mid_bits[0]) + NB_W'(mid_bits[2])
          + NB_W'(dn_bits[0]) + NB_W'(dn_bits[1]) + NB_W'(dn_bits[2]);
    res.alive = mid_bits[1];
    if (mid_bits[1]) begin
      res.next_alive = (count >= SURVIVE_LOW) && (count <= SURVIVE_HIGH);
    end else begin
      res.next_alive = (count == BIRTH_COUNT);
    end
  end

endmodule

[src/lge_row_bank.sv]
// one cell bank, one grid row per word, registered read
// depends on lge_pkg only through the parameters handed down
module lge_row_bank #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [COLS-1:0]         wdata,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [COLS-1:0]         rdata
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/life_generation_engine.sv]
// life generation engine top level: sequencer, config registers, result register
// depends on lge_pkg, lge_row_bank, lge_cell_rule
//
// usage
//   s_tuser holds the function (load, step, read); s_tdata the cell and value.
//   one result per request on m_tdata; cfg_we/cfg_index/cfg_data set the grid
//   size (index 0 rows, index 1 columns). The user must write them only while
//   the block is idle; the block itself does not enforce it.
// sequence
//   load and read: the addressed row is fetched, then the result is registered.
//   step: every row of the grid in use is fetched once and then walked one
//   column per cycle through the shared rule unit; rows past the grid are
//   written dead. s_tready stays low until the step result is registered.
// reset
//   both banks are cleared one row per cycle after reset, during which no
//   request is taken; config writes are taken at any time.
// stall
//   a finished result waits in the output register; the next request can be
//   taken meanwhile, and its result waits until the register is free.
module life_generation_engine #(
  parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cell_row[5:0], cell_col[11:6], alive_in[12], zero fill
  input  logic [lge_pkg::IN_DATA_W-1:0]    s_tdata,
  // func[1:0]
  input  lge_pkg::func_t                   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // alive_out[0], population[13:1], all_dead[14], zero fill
  output logic [lge_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  lge_pkg::cfg_idx_t                cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]        cfg_data
);
  import lge_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int PW = MAX_COLS + 2;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLS - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CELL   = 4'd2;
  localparam logic [3:0] S_PRIME  = 4'd3;
  localparam logic [3:0] S_LOADDN = 4'd4;
  localparam logic [3:0] S_ROW    = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_ZERO   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]         state;
  logic [CFG_W-1:0]   rows_cfg, cols_cfg;
  logic               bank_sel;
  logic [RW-1:0]      r;
  logic [CW-1:0]      c;
  func_t              req_func;
  logic [FIELD_W-1:0] req_row, req_col;
  logic               req_alive;
  logic [MAX_COLS-1:0] up_r, mid_r, dn_r, new_row;
  logic [PW-1:0]      up_s, mid_s, dn_s;
  logic [POP_W-1:0]   pop;
  logic               res_alive, res_dead;
  logic [POP_W-1:0]   res_pop;

  logic [FIELD_W-1:0] in_row, in_col;
  logic               in_alive;
  logic [CFG_W-1:0]   nr, nc;
  logic [MAX_COLS-1:0] colmask, cur_rdata, a_rdata, b_rdata, dn_v, cell_mod;
  logic [RW-1:0]      rd_addr, wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic               wr_a, wr_b, wr_cur, wr_nxt;
  logic               cell_in_grid, col_ok, next_row_live, new_bit;
  logic [CW-1:0]      colsel;
  rule_out_t          rule;

  assign in_row   = s_tdata[FIELD_W-1:0];
  assign in_col   = s_tdata[2*FIELD_W-1:FIELD_W];
  assign in_alive = s_tdata[2*FIELD_W];

  assign nr = (int'(rows_cfg) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_cfg;
  assign nc = (int'(cols_cfg) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_cfg;

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_mask
    assign colmask[i] = (i < int'(nc));
  end

  assign s_tready      = (state == S_IDLE);
  assign cur_rdata     = bank_sel ? b_rdata : a_rdata;
  assign cell_in_grid  = ({1'b0, req_row} < nr) && ({1'b0, req_col} < nc);
  assign colsel        = CW'(req_col);
  assign col_ok        = (int'(c) < int'(nc));
  assign next_row_live = ((int'(r) + 1) < int'(nr));
  assign dn_v          = next_row_live ? (cur_rdata & colmask) : '0;
  assign new_bit       = rule.next_alive & col_ok;

  always_comb begin
    cell_mod = cur_rdata;
    cell_mod[colsel] = req_alive;
  end

  // read address: the row to fetch for the coming cycle
  always_comb begin
    rd_addr = '0;
    unique case (state)
      S_IDLE:  rd_addr = (s_tuser == FUNC_STEP) ? '0 : RW'(in_row);
      S_PRIME: rd_addr = RW'(int'(r) + 1);
      S_WRITE: rd_addr = RW'(int'(r) + 2);
      default: rd_addr = '0;
    endcase
  end

  // write port: clear sweep, single-cell update, or new generation rows
  always_comb begin
    wr_cur  = 1'b0;
    wr_nxt  = 1'b0;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    wr_addr = r;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_a = 1'b1;
        wr_b = 1'b1;
      end
      S_CELL: begin
        wr_cur  = (req_func == FUNC_LOAD) && cell_in_grid;
        wr_addr = RW'(req_row);
        wr_data = cell_mod;
      end
      S_WRITE: begin
        wr_nxt  = 1'b1;
        wr_data = new_row;
      end
      S_ZERO: wr_nxt = 1'b1;
      default: wr_cur = 1'b0;
    endcase
    if (wr_cur) begin
      wr_a = ~bank_sel;
      wr_b = bank_sel;
    end
    if (wr_nxt) begin
      wr_a = bank_sel;
      wr_b = ~bank_sel;
    end
  end

  lge_row_bank #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_bank_a (
    .clk(clk), .we(wr_a), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(a_rdata)
  );

  lge_row_bank #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_bank_b (
    .clk(clk), .we(wr_b), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(b_rdata)
  );

  lge_cell_rule u_rule (
    .up_bits(up_s[2:0]), .mid_bits(mid_s[2:0]), .dn_bits(dn_s[2:0]), .res(rule)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      r        <= '0;
      bank_sel <= 1'b0;
      rows_cfg <= CFG_RESET;
      cols_cfg <= CFG_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) begin
          rows_cfg <= cfg_data;
        end else begin
          cols_cfg <= cfg_data;
        end
      end
      // in S_OUT the output stage below decides the valid flag
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (r == LAST_ROW) begin
            r     <= '0;
            state <= S_IDLE;
          end else begin
            r <= r + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_func  <= s_tuser;
            req_row   <= in_row;
            req_col   <= in_col;
            req_alive <= in_alive;
            res_alive <= 1'b0;
            res_pop   <= '0;
            res_dead  <= 1'b0;
            if (s_tuser == FUNC_STEP) begin
              r     <= '0;
              up_r  <= '0;
              pop   <= '0;
              state <= S_PRIME;
            end else if (s_tuser == FUNC_LOAD || s_tuser == FUNC_READ) begin
              state <= S_CELL;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_CELL: begin
          if (req_func == FUNC_READ) begin
            res_alive <= cell_in_grid & cur_rdata[colsel];
          end
          state <= S_OUT;
        end
        S_PRIME: begin
          mid_r <= cur_rdata & colmask;
          state <= (nr == '0) ? S_ZERO : S_LOADDN;
        end
        S_LOADDN: begin
          dn_r  <= dn_v;
          up_s  <= {1'b0, up_r, 1'b0};
          mid_s <= {1'b0, mid_r, 1'b0};
          dn_s  <= {1'b0, dn_v, 1'b0};
          c     <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          new_row <= {new_bit, new_row[MAX_COLS-1:1]};
          if (rule.alive && pop != POP_MAX) begin
            pop <= pop + 1'b1;
          end
          up_s  <= up_s >> 1;
          mid_s <= mid_s >> 1;
          dn_s  <= dn_s >> 1;
          c     <= c + 1'b1;
          if (c == LAST_COL) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          up_r  <= mid_r;
          mid_r <= dn_r;
          if (r == LAST_ROW) begin
            bank_sel <= ~bank_sel;
            res_pop  <= pop;
            res_dead <= (pop == '0);
            state    <= S_OUT;
          end else begin
            r     <= r + 1'b1;
            state <= next_row_live ? S_LOADDN : S_ZERO;
          end
        end
        S_ZERO: begin
          if (r == LAST_ROW) begin
            bank_sel <= ~bank_sel;
            res_pop  <= pop;
            res_dead <= (pop == '0);
            state    <= S_OUT;
          end else begin
            r <= r + 1'b1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, res_dead, res_pop, res_alive};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/lge_checker.sv]
// port-level checker for the life generation engine, bound to the top level
// depends on life_generation_engine_macros.svh
`include "life_generation_engine_macros.svh"

module lge_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a taken request leaves the block busy in the next cycle
  `LGE_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready right after a request")

  // a stalled result holds
  `LGE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // a result with the alive bit set carries no population and no extinction flag
  `LGE_ASSERT_NOW(a_read_fields, m_tvalid && m_tdata[0], m_tdata[15:1] == 15'd0, "read result has step fields")

  // extinction means a zero population, a clear alive bit and a clear top bit
  `LGE_ASSERT_NOW(a_dead_pop, m_tvalid && m_tdata[14], m_tdata[13:0] == 14'd0 && !m_tdata[15], "all dead with population")

  // a new result appears only after a busy cycle
  `LGE_ASSERT_NOW(a_result_after_busy, $rose(m_tvalid), $past(!s_tready), "result without a busy cycle")

endmodule

bind life_generation_engine lge_checker u_lge_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
